FILE: sv/bdr_pkg.sv
package bdr_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CodeWidth = 8;
   localparam int unsigned MsWidth   = 16;
   localparam int unsigned RegCount  = 8;
   localparam int unsigned AddrWidth = 5;
   localparam int unsigned DataWidth = 32;

   // Glitch filter hold times, strictly exceeded before the filtered level moves
   localparam logic [TimeWidth-1:0] FILTER_HIGH_MS = 32'd20;
   localparam logic [TimeWidth-1:0] FILTER_LOW_MS  = 32'd20;

   typedef enum logic [2:0] {
      MODE_OFF      = 3'd0,
      MODE_ONE_SHOT = 3'd1,
      MODE_TWO_CODE = 3'd2,
      MODE_REPEAT   = 3'd3,
      MODE_SILENT   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      REG_MODE          = 3'd0,
      REG_ACTIVE_HIGH   = 3'd1,
      REG_KEY_CODE      = 3'd2,
      REG_LONG_CODE     = 3'd3,
      REG_DEBOUNCE      = 3'd4,
      REG_LONG_PRESS    = 3'd5,
      REG_REPEAT_DELAY  = 3'd6,
      REG_REPEAT_PERIOD = 3'd7
   } reg_index_type;

   localparam logic [2:0]         RESET_MODE          = 3'd3;
   localparam logic               RESET_ACTIVE_HIGH   = 1'b0;
   localparam logic [CodeWidth-1:0] RESET_KEY_CODE    = 8'd0;
   localparam logic [CodeWidth-1:0] RESET_LONG_CODE   = 8'd0;
   localparam logic [MsWidth-1:0] RESET_DEBOUNCE      = 16'd50;
   localparam logic [MsWidth-1:0] RESET_LONG_PRESS    = 16'd1000;
   localparam logic [MsWidth-1:0] RESET_REPEAT_DELAY  = 16'd500;
   localparam logic [MsWidth-1:0] RESET_REPEAT_PERIOD = 16'd100;

   typedef struct packed {
      logic [2:0]           mode;
      logic                 active_high;
      logic [CodeWidth-1:0] key_code;
      logic [CodeWidth-1:0] long_code;
      logic [MsWidth-1:0]   debounce_ms;
      logic [MsWidth-1:0]   long_press_ms;
      logic [MsWidth-1:0]   repeat_delay_ms;
      logic [MsWidth-1:0]   repeat_period_ms;
   } cfg_type;

endpackage

FILE: sv/bdr_if.sv
interface bdr_req_if;
   logic        valid;
   logic        ready;
   logic        pin_level;
   logic [31:0] now_ms;
   logic        locked;

   modport source (output valid, output pin_level, output now_ms, output locked,
                   input ready);
   modport sink   (input valid, input pin_level, input now_ms, input locked,
                   output ready);
endinterface

interface bdr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] event_code;
   logic       pressed;

   modport source (output valid, output event_code, output pressed, input ready);
   modport sink   (input valid, input event_code, input pressed, output ready);
endinterface

FILE: sv/button_debounce_repeat.sv
// Pushbutton debounce with one-shot, short/long and auto-repeat key codes.
// req_ch carries one scan item: raw pin level, a wrapping millisecond
// timestamp and a lock flag. rsp_ch returns exactly one item per scan: the
// key code raised by that scan (0 for none) and the filtered pressed state.
// Both channels use valid/ready; an item moves when both are high.
// The csr_ APB port holds mode, polarity, the two codes and the four timing
// settings at byte addresses 0, 4, ..., 28; write them only while idle.
// The scan is held in the input register while the filter and code logic
// feed the result register, from which its result item is valid.
// One scan is taken every cycle while the receiver does not stall; the
// single state update per scan sits between those two registers and sets
// that rate.
// When the receiver stalls, the result register holds and req_ch.ready
// drops once the input register holds a scan, so at most one more is taken.
// Reset is synchronous and restores the register defaults and clears the
// filter and press timing state; no item is in flight afterwards.
module button_debounce_repeat (
   input  logic                          clock,
   input  logic                          reset,
   bdr_req_if.sink                       req_ch,
   bdr_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bdr_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [bdr_pkg::DataWidth-1:0] csr_pwdata,
   output logic [bdr_pkg::DataWidth-1:0] csr_prdata,
   output logic                          csr_pready
);
   import bdr_pkg::*;

   cfg_type cfg;

   bdr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bdr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: sv/bdr_csr.sv
module bdr_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bdr_pkg::AddrWidth-1:0]    csr_paddr,
   input  logic [bdr_pkg::DataWidth-1:0]    csr_pwdata,
   output logic [bdr_pkg::DataWidth-1:0]    csr_prdata,
   output logic                             csr_pready,
   output bdr_pkg::cfg_type                 cfg
);
   import bdr_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          write_strobe;

   assign reg_index    = reg_index_type'(csr_paddr[AddrWidth-1:2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready   = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode             <= RESET_MODE;
         cfg_ff.active_high      <= RESET_ACTIVE_HIGH;
         cfg_ff.key_code         <= RESET_KEY_CODE;
         cfg_ff.long_code        <= RESET_LONG_CODE;
         cfg_ff.debounce_ms      <= RESET_DEBOUNCE;
         cfg_ff.long_press_ms    <= RESET_LONG_PRESS;
         cfg_ff.repeat_delay_ms  <= RESET_REPEAT_DELAY;
         cfg_ff.repeat_period_ms <= RESET_REPEAT_PERIOD;
      end else if (write_strobe) begin
         unique case (reg_index)
            REG_MODE:          cfg_ff.mode             <= csr_pwdata[2:0];
            REG_ACTIVE_HIGH:   cfg_ff.active_high      <= csr_pwdata[0];
            REG_KEY_CODE:      cfg_ff.key_code         <= csr_pwdata[CodeWidth-1:0];
            REG_LONG_CODE:     cfg_ff.long_code        <= csr_pwdata[CodeWidth-1:0];
            REG_DEBOUNCE:      cfg_ff.debounce_ms      <= csr_pwdata[MsWidth-1:0];
            REG_LONG_PRESS:    cfg_ff.long_press_ms    <= csr_pwdata[MsWidth-1:0];
            REG_REPEAT_DELAY:  cfg_ff.repeat_delay_ms  <= csr_pwdata[MsWidth-1:0];
            REG_REPEAT_PERIOD: cfg_ff.repeat_period_ms <= csr_pwdata[MsWidth-1:0];
            default:           cfg_ff.mode             <= cfg_ff.mode;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MODE:          csr_prdata = {29'd0, cfg_ff.mode};
         REG_ACTIVE_HIGH:   csr_prdata = {31'd0, cfg_ff.active_high};
         REG_KEY_CODE:      csr_prdata = {24'd0, cfg_ff.key_code};
         REG_LONG_CODE:     csr_prdata = {24'd0, cfg_ff.long_code};
         REG_DEBOUNCE:      csr_prdata = {16'd0, cfg_ff.debounce_ms};
         REG_LONG_PRESS:    csr_prdata = {16'd0, cfg_ff.long_press_ms};
         REG_REPEAT_DELAY:  csr_prdata = {16'd0, cfg_ff.repeat_delay_ms};
         REG_REPEAT_PERIOD: csr_prdata = {16'd0, cfg_ff.repeat_period_ms};
         default:           csr_prdata = '0;
      endcase
   end

endmodule

FILE: sv/bdr_core.sv
module bdr_core (
   input  logic             clock,
   input  logic             reset,
   input  bdr_pkg::cfg_type cfg,
   bdr_req_if.sink          req_ch,
   bdr_rsp_if.source        rsp_ch
);
   import bdr_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 pin_ff;
   logic [TimeWidth-1:0] now_ff;
   logic                 locked_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [CodeWidth-1:0] code_ff, code_in;
   logic                 pressed_ff;

   // scan state
   logic                 last_level_ff, last_level_in;
   logic [TimeWidth-1:0] last_change_ff, last_change_in;
   logic                 filtered_ff, filtered_in;
   logic [TimeWidth-1:0] press_start_ff, press_start_in;
   logic                 press_valid_ff, press_valid_in;
   logic                 emitted_ff, emitted_in;

   logic                 req_take;
   logic                 advance;
   logic                 level;
   logic [TimeWidth-1:0] since_change;
   logic [TimeWidth-1:0] held;
   logic [TimeWidth-1:0] repeat_limit;
   mode_type             mode_eff;

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.event_code = code_ff;
   assign rsp_ch.pressed    = pressed_ff;

   assign level        = pin_ff ^ ~cfg.active_high;
   assign since_change = now_ff - last_change_ff;
   assign repeat_limit = {16'd0, cfg.debounce_ms} + {16'd0, cfg.repeat_delay_ms};
   assign mode_eff     = (cfg.mode > MODE_SILENT) ? MODE_ONE_SHOT : mode_type'(cfg.mode);

   always_comb begin
      last_level_in  = last_level_ff;
      last_change_in = last_change_ff;
      filtered_in    = filtered_ff;
      press_start_in = press_start_ff;
      press_valid_in = press_valid_ff;
      emitted_in     = emitted_ff;
      code_in        = '0;
      held           = '0;

      if (locked_ff) begin
         // drop press timing and the last raw level, keep the filtered level
         press_start_in = '0;
         press_valid_in = 1'b0;
         last_level_in  = 1'b0;
      end else begin
         if (last_level_ff != level) begin
            last_level_in  = level;
            last_change_in = now_ff;
         end else if (level) begin
            if (since_change > FILTER_HIGH_MS) begin
               if (!filtered_ff) begin
                  press_start_in = last_change_ff;
                  press_valid_in = 1'b1;
               end
               filtered_in = 1'b1;
            end
         end else begin
            if (!filtered_ff && press_valid_ff) begin
               press_start_in = '0;
               press_valid_in = 1'b0;
            end else if (since_change > FILTER_LOW_MS) begin
               filtered_in = 1'b0;
            end
         end

         if (press_valid_in) begin
            held = now_ff - press_start_in;
         end

         unique case (mode_eff)
            MODE_ONE_SHOT: begin
               if (filtered_in) begin
                  if (held >= {16'd0, cfg.debounce_ms} && !emitted_ff) begin
                     code_in    = cfg.key_code;
                     emitted_in = 1'b1;
                  end
               end else begin
                  emitted_in = 1'b0;
               end
            end
            MODE_TWO_CODE: begin
               if (filtered_in) begin
                  if (held > {16'd0, cfg.long_press_ms} && !emitted_ff) begin
                     code_in    = cfg.long_code;
                     emitted_in = 1'b1;
                  end
               end else begin
                  if (held > {16'd0, cfg.debounce_ms} && held < {16'd0, cfg.long_press_ms}) begin
                     code_in = cfg.key_code;
                  end
                  emitted_in = 1'b0;
               end
            end
            MODE_REPEAT: begin
               if (filtered_in) begin
                  if (held >= {16'd0, cfg.debounce_ms} && !emitted_ff) begin
                     code_in    = cfg.key_code;
                     emitted_in = 1'b1;
                  end else if (held > repeat_limit) begin
                     // emit the key code, re-arm and push the press start on by one period
                     emitted_in     = 1'b0;
                     code_in        = cfg.key_code;
                     press_start_in = press_start_in + {16'd0, cfg.repeat_period_ms};
                  end
               end else begin
                  emitted_in = 1'b0;
               end
            end
            default: begin
               code_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         last_level_ff  <= 1'b0;
         last_change_ff <= '0;
         filtered_ff    <= 1'b0;
         press_start_ff <= '0;
         press_valid_ff <= 1'b0;
         emitted_ff     <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            last_level_ff  <= last_level_in;
            last_change_ff <= last_change_in;
            filtered_ff    <= filtered_in;
            press_start_ff <= press_start_in;
            press_valid_ff <= press_valid_in;
            emitted_ff     <= emitted_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         pin_ff    <= req_ch.pin_level;
         now_ff    <= req_ch.now_ms;
         locked_ff <= req_ch.locked;
      end
      if (advance) begin
         code_ff    <= code_in;
         pressed_ff <= filtered_in;
      end
   end

endmodule
